// File: rtl/msrc_pkg.sv
// ----------------------------------------------------------------------------
// msrc_pkg
// Types and constants shared by the sensor response checker and its channels.
// ----------------------------------------------------------------------------
package msrc_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_BYTE  = 2'd1,
    MODE_TICK  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_MISMATCH = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

  localparam logic [1:0] REG_EXP_ADDR = 2'd0;
  localparam logic [1:0] REG_EXP_FUNC = 2'd1;
  localparam logic [1:0] REG_TIMEOUT  = 2'd2;

  localparam logic [7:0]  RST_EXP_ADDR = 8'h60;
  localparam logic [7:0]  RST_EXP_FUNC = 8'h03;
  localparam logic [5:0]  RST_TIMEOUT  = 6'd25;
  localparam logic [5:0]  TICK_MAX     = 6'd63;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [15:0] temperature;
    logic [15:0]        moisture;
    logic [15:0]        conductivity;
  } out_item_t;

  typedef struct packed {
    logic [1:0] addr;
    logic [7:0] wdata;
  } cfg_wr_t;

endpackage

// File: rtl/msrc_chan_if.sv
// ----------------------------------------------------------------------------
// msrc_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface msrc_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/msrc_crc16.sv
// ----------------------------------------------------------------------------
// msrc_crc16
// One-byte update of CRC-16/Modbus (reflected, polynomial 0xA001).
// ----------------------------------------------------------------------------
module msrc_crc16 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc_out
);
  import msrc_pkg::*;

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, byte_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

// File: rtl/modbus_sensor_response_check.sv
// ----------------------------------------------------------------------------
// modbus_sensor_response_check
// Checks a Modbus RTU holding-register reply from a soil sensor byte by byte
// and reports status plus temperature, moisture and conductivity.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                   | notes
//  in_ch   | in  | mode, data_byte                           | start/byte/tick
//  out_ch  | out | status, temperature, moisture, conductivity | zero or one per item
//  cfg_ch  | in  | addr, wdata                               | always ready
//
//  One item per cycle while out_ch does not stall: input register,
//  combinational CRC byte update and frame check, then the result register.
//  Reset is synchronous (rst_n low): idle, CRC 0xFFFF, default registers.
//  A stalled result holds the pipe; the input register still takes a
//  transfer when it is empty.
// ----------------------------------------------------------------------------
module modbus_sensor_response_check #(
  parameter int FRAME_LEN = 11
) (
  input logic         clk,
  input logic         rst_n,
  msrc_chan_if.sink   in_ch,
  msrc_chan_if.source out_ch,
  msrc_chan_if.sink   cfg_ch
);
  import msrc_pkg::*;

  localparam int CW    = $clog2(FRAME_LEN + 1);
  localparam int FDEP  = FRAME_LEN - 1;       // last byte is never stored
  localparam int IW    = $clog2(FDEP);
  localparam logic [CW-1:0] LAST_IDX = CW'(FRAME_LEN - 1);
  localparam logic [CW-1:0] CRC_END  = CW'(FRAME_LEN - 2);

  // configuration
  logic [7:0] exp_addr_r;
  logic [7:0] exp_func_r;
  logic [5:0] timeout_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r <= RST_EXP_ADDR;
      exp_func_r <= RST_EXP_FUNC;
      timeout_r  <= RST_TIMEOUT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.addr)
        REG_EXP_ADDR: exp_addr_r <= cfg_ch.data.wdata;
        REG_EXP_FUNC: exp_func_r <= cfg_ch.data.wdata;
        REG_TIMEOUT:  timeout_r  <= cfg_ch.data.wdata[5:0];
        default: ;
      endcase
    end
  end

  // input register
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     out_valid_r;
  out_item_t out_item_r;
  logic     adv;
  logic     take;

  assign adv         = !out_valid_r || out_ch.ready;
  assign take        = s1_valid_r && adv;
  assign in_ch.ready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_item_r <= in_ch.data;
    end
  end

  // frame state
  logic          rx_r, rx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [15:0]   crc_r, crc_nxt;
  logic [5:0]    tick_r, tick_nxt;
  logic [7:0]    frame_r [FDEP];
  logic [15:0]   crc_upd;
  logic [7:0]    vbyte [6];            // frame bytes 3 to 8
  logic          emit;
  out_item_t     res;

  msrc_crc16 u_crc (
    .crc_in  (crc_r),
    .byte_in (s1_item_r.data_byte),
    .crc_out (crc_upd)
  );

  for (genvar g = 0; g < 6; g++) begin : g_vbyte
    if (g + 3 < FRAME_LEN - 2) begin : g_in
      assign vbyte[g] = frame_r[g+3];
    end else begin : g_zero
      assign vbyte[g] = '0;
    end
  end

  always_comb begin
    logic [5:0]  tick_inc;
    logic [15:0] got;
    rx_nxt   = rx_r;
    cnt_nxt  = cnt_r;
    crc_nxt  = crc_r;
    tick_nxt = tick_r;
    emit     = 1'b0;
    res      = '0;
    tick_inc = (tick_r < TICK_MAX) ? tick_r + 6'd1 : tick_r;
    got      = {s1_item_r.data_byte, frame_r[FDEP-1]};
    case (s1_item_r.mode)
      MODE_START: begin
        rx_nxt   = 1'b1;
        cnt_nxt  = '0;
        crc_nxt  = CRC_INIT;
        tick_nxt = '0;
      end
      MODE_BYTE: begin
        if (rx_r) begin
          if (cnt_r < CRC_END) crc_nxt = crc_upd;
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == LAST_IDX) begin
            rx_nxt = 1'b0;
            emit   = 1'b1;
            if (frame_r[0] == exp_addr_r && frame_r[1] == exp_func_r &&
                got == crc_r) begin
              res.status       = STATUS_OK;
              res.temperature  = {vbyte[0], vbyte[1]};
              res.moisture     = {vbyte[2], vbyte[3]};
              res.conductivity = {vbyte[4], vbyte[5]};
            end else begin
              res.status = STATUS_MISMATCH;
            end
          end
        end
      end
      MODE_TICK: begin
        if (rx_r) begin
          tick_nxt = tick_inc;
          if (tick_inc >= timeout_r) begin
            rx_nxt     = 1'b0;
            emit       = 1'b1;
            res.status = STATUS_TIMEOUT;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r   <= 1'b0;
      cnt_r  <= '0;
      crc_r  <= CRC_INIT;
      tick_r <= '0;
    end else if (take) begin
      rx_r   <= rx_nxt;
      cnt_r  <= cnt_nxt;
      crc_r  <= crc_nxt;
      tick_r <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && rx_r && s1_item_r.mode == MODE_BYTE && cnt_r < LAST_IDX) begin
      frame_r[cnt_r[IW-1:0]] <= s1_item_r.data_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= take && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_item_r <= res;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule
